// ===== src/ptx_pkg.sv =====
// Shared types and constants for the periodic transmit scheduler.
// Used by every module under src; no dependencies of its own.
package ptx_pkg;

  localparam int NUM_SLOTS     = 2;
  localparam int QUEUE_DEPTH   = 10;
  localparam int NUM_MAILBOXES = 3;

  localparam int PERIOD_W = 16;
  localparam int MASK_W   = 3;
  localparam int MBOX_W   = 2;
  localparam int QIDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int QSUM_W   = QCNT_W + 1;

  localparam int CFG_INDEX_W = 8;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_A = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_B = CFG_INDEX_W'(1);

  // Input word kinds
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_SERVICE = 1'b1;

  // Per-slot tick control from the walk
  typedef struct packed {
    logic visit;
    logic room;
  } slot_ctl_t;

  // Per-slot tick outcome
  typedef struct packed {
    logic push;
    logic stop;
  } slot_req_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic [QCNT_W-1:0] queue_level;
    logic              dropped;
    logic              message_slot;
    logic [MBOX_W-1:0] mbox_index;
    logic              assigned;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// ===== src/ptx_slot.sv =====
// One periodic slot: period register, countdown and pending flag.
// Depends on ptx_pkg.
module ptx_slot (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [ptx_pkg::PERIOD_W-1:0]  load_value,
  input  logic                          tick,
  input  ptx_pkg::slot_ctl_t            ctl,
  output ptx_pkg::slot_req_t            req
);

  logic [ptx_pkg::PERIOD_W-1:0] period;
  logic [ptx_pkg::PERIOD_W-1:0] countdown;
  logic                         pending;

  logic enabled;
  logic expired;
  logic pend_mid;
  logic active;

  assign enabled  = (period != '0);
  assign expired  = (countdown == '0);
  assign pend_mid = pending | expired;
  assign active   = tick & ctl.visit & enabled;

  assign req.push = active & pend_mid & ctl.room;
  assign req.stop = active & pend_mid & ~ctl.room;

  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= '0;
      countdown <= '0;
      pending   <= 1'b0;
    end else if (load) begin
      period    <= load_value;
      countdown <= load_value;
    end else if (active) begin
      countdown <= expired ? period : countdown - 1'b1;
      // keep pending while the queue has no room
      pending   <= pend_mid & ~ctl.room;
    end
  end

endmodule

// ===== src/ptx_send_queue.sv =====
// Send queue: ring of slot indexes with head pointer and fill count.
// Takes up to one push per slot on a tick, one pop on a service word. Depends on ptx_pkg.
module ptx_send_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push_a,
  input  logic                        push_b,
  input  logic                        pop,
  output logic [ptx_pkg::QCNT_W-1:0]  level,
  output logic [ptx_pkg::QCNT_W-1:0]  level_next,
  output logic                        nonempty,
  output logic                        head_slot
);

  logic                        mem [ptx_pkg::QUEUE_DEPTH];
  logic [ptx_pkg::QIDX_W-1:0]  head;
  logic [ptx_pkg::QCNT_W-1:0]  count;

  logic [ptx_pkg::QIDX_W-1:0]  tail_a;
  logic [ptx_pkg::QIDX_W-1:0]  tail_b;
  logic                        do_pop;

  function automatic logic [ptx_pkg::QIDX_W-1:0] wrap(input logic [ptx_pkg::QSUM_W-1:0] x);
    logic [ptx_pkg::QSUM_W-1:0] r;
    r = (x >= ptx_pkg::QSUM_W'(ptx_pkg::QUEUE_DEPTH)) ?
        x - ptx_pkg::QSUM_W'(ptx_pkg::QUEUE_DEPTH) : x;
    return r[ptx_pkg::QIDX_W-1:0];
  endfunction

  assign tail_a = wrap(ptx_pkg::QSUM_W'(head) + ptx_pkg::QSUM_W'(count));
  assign tail_b = wrap(ptx_pkg::QSUM_W'(head) + ptx_pkg::QSUM_W'(count)
                       + ptx_pkg::QSUM_W'(push_a));

  assign nonempty  = (count != '0);
  assign do_pop    = pop & nonempty;
  assign head_slot = nonempty ? mem[head] : 1'b0;
  assign level     = count;
  assign level_next = count + ptx_pkg::QCNT_W'(push_a) + ptx_pkg::QCNT_W'(push_b)
                      - ptx_pkg::QCNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[tail_a] <= 1'b0;
    end
    if (push_b) begin
      mem[tail_b] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      count <= level_next;
      if (do_pop) begin
        head <= (head == ptx_pkg::QIDX_W'(ptx_pkg::QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      end
    end
  end

endmodule

// ===== src/ptx_mailbox_alloc.sv =====
// Mailbox busy flags: free by done mask, then load the lowest free mailbox.
// Depends on ptx_pkg.
module ptx_mailbox_alloc (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        service,
  input  logic [ptx_pkg::MASK_W-1:0]  done_mask,
  input  logic                        take,
  output logic                        assigned,
  output logic [ptx_pkg::MBOX_W-1:0]  mbox_index
);

  logic [ptx_pkg::NUM_MAILBOXES-1:0] busy;
  logic [ptx_pkg::NUM_MAILBOXES-1:0] freed;
  logic [ptx_pkg::NUM_MAILBOXES-1:0] busy_next;
  logic                              any_free;
  logic [ptx_pkg::MBOX_W-1:0]        pick;

  always_comb begin
    for (int i = 0; i < ptx_pkg::NUM_MAILBOXES; i++) begin
      // mask bits beyond the mailbox count are ignored
      if (i < ptx_pkg::MASK_W) begin
        freed[i] = busy[i] & ~done_mask[i];
      end else begin
        freed[i] = busy[i];
      end
    end
    any_free = 1'b0;
    pick     = '0;
    for (int i = ptx_pkg::NUM_MAILBOXES - 1; i >= 0; i--) begin
      if (!freed[i]) begin
        any_free = 1'b1;
        pick     = ptx_pkg::MBOX_W'(i);
      end
    end
    busy_next = freed;
    if (take && any_free) begin
      busy_next[pick] = 1'b1;
    end
  end

  assign assigned   = take & any_free;
  assign mbox_index = assigned ? pick : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (service) begin
      busy <= busy_next;
    end
  end

endmodule

// ===== src/periodic_tx_scheduler_unit.sv =====
// Top level of the periodic transmit scheduler: stream ports, slot walk, result register.
// Depends on ptx_pkg, ptx_slot, ptx_send_queue, ptx_mailbox_alloc.
//
//   channel   | dir | handshake              | payload
//   ----------+-----+------------------------+------------------------------------------
//   s_axis    | in  | s_axis_tvalid/tready   | tdata: tx_done_mask; tuser: kind
//   m_axis    | out | m_axis_tvalid/tready   | tdata: assigned, mailbox, message_slot,
//             |     |                        |        dropped, queue_level
//   cfg       | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data (period registers)
//
// One word per cycle unless the output register stalls: the whole tick walk or service
// step is applied to the slot, queue and mailbox state in the cycle the word is accepted,
// and its result is loaded into the output register with that update. Input is taken
// whenever the output register is empty or being drained. Reset is synchronous and
// clears all control state at once; queue entries need no clearing. cfg is always ready.
module periodic_tx_scheduler_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ptx_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [2:0] tx_done_mask
  input  logic                              s_axis_tuser,  // [0] kind
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] assigned, [2:1] mailbox, [3] message_slot, [4] dropped, [8:5] queue_level
  output logic [ptx_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ptx_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ptx_pkg::PERIOD_W-1:0]      cfg_data
);

  logic accept;
  logic tick;
  logic service;
  logic cfg_write;

  ptx_pkg::slot_ctl_t ctl_a;
  ptx_pkg::slot_ctl_t ctl_b;
  ptx_pkg::slot_req_t req_a;
  ptx_pkg::slot_req_t req_b;

  logic [ptx_pkg::QCNT_W-1:0] level;
  logic [ptx_pkg::QCNT_W-1:0] level_next;
  logic                       nonempty;
  logic                       head_slot;
  logic                       assigned;
  logic [ptx_pkg::MBOX_W-1:0] mbox_index;

  ptx_pkg::result_t result;
  ptx_pkg::result_t result_reg;
  logic             out_valid;

  assign s_axis_tready = ~out_valid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign tick          = accept & (s_axis_tuser == ptx_pkg::KIND_TICK);
  assign service       = accept & (s_axis_tuser == ptx_pkg::KIND_SERVICE);
  assign cfg_ready     = 1'b1;
  assign cfg_write     = cfg_valid & cfg_ready;

  // Walk slot 0 then slot 1; a full queue on a pending slot stops the walk.
  assign ctl_a.visit = 1'b1;
  assign ctl_a.room  = (level < ptx_pkg::QCNT_W'(ptx_pkg::QUEUE_DEPTH));
  assign ctl_b.visit = ~req_a.stop;
  assign ctl_b.room  = ((ptx_pkg::QSUM_W'(level) + ptx_pkg::QSUM_W'(req_a.push))
                        < ptx_pkg::QSUM_W'(ptx_pkg::QUEUE_DEPTH));

  ptx_slot u_slot_a (
    .clk        (clk),
    .rst        (rst),
    .load       (cfg_write && cfg_index == ptx_pkg::CFG_PERIOD_A),
    .load_value (cfg_data),
    .tick       (tick),
    .ctl        (ctl_a),
    .req        (req_a)
  );

  ptx_slot u_slot_b (
    .clk        (clk),
    .rst        (rst),
    .load       (cfg_write && cfg_index == ptx_pkg::CFG_PERIOD_B),
    .load_value (cfg_data),
    .tick       (tick),
    .ctl        (ctl_b),
    .req        (req_b)
  );

  ptx_send_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_a     (req_a.push),
    .push_b     (req_b.push),
    .pop        (service),
    .level      (level),
    .level_next (level_next),
    .nonempty   (nonempty),
    .head_slot  (head_slot)
  );

  ptx_mailbox_alloc u_mbox (
    .clk        (clk),
    .rst        (rst),
    .service    (service),
    .done_mask  (s_axis_tdata[ptx_pkg::MASK_W-1:0]),
    .take       (service & nonempty),
    .assigned   (assigned),
    .mbox_index (mbox_index)
  );

  always_comb begin
    result.assigned     = assigned;
    result.mbox_index   = mbox_index;
    result.message_slot = service & head_slot;
    result.dropped      = service & nonempty & ~assigned;
    result.queue_level  = level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_reg <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(ptx_pkg::OUT_DATA_W - ptx_pkg::RESULT_W){1'b0}}, result_reg};

  a_level_bound : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_reg.queue_level <= ptx_pkg::QCNT_W'(ptx_pkg::QUEUE_DEPTH))
    else $error("queue level above depth");

  a_assign_xor_drop : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(result_reg.assigned && result_reg.dropped))
    else $error("word both assigned and dropped");

  a_tick_no_pop : assert property (@(posedge clk) disable iff (rst)
    tick |=> !result_reg.assigned && !result_reg.dropped && !result_reg.message_slot)
    else $error("tick dequeued a message");

  a_tick_level_grows : assert property (@(posedge clk) disable iff (rst)
    tick |=> result_reg.queue_level >= $past(level))
    else $error("tick lowered queue level");

endmodule

// ===== tb/periodic_tx_scheduler_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the periodic transmit scheduler: tracks slot, queue and mailbox
// state from the accepted words and compares every result word. Depends on ptx_pkg.
module periodic_tx_scheduler_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [ptx_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [2:0] tx_done_mask
  input  logic                            s_axis_tuser,   // [0] kind
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] assigned, [2:1] mailbox, [3] message_slot, [4] dropped, [8:5] queue_level
  input  logic [ptx_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ptx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ptx_pkg::PERIOD_W-1:0]    cfg_data,
  output int                              fail_count,
  output int                              outstanding
);

  logic [ptx_pkg::PERIOD_W-1:0] slot_period    [ptx_pkg::NUM_SLOTS];
  logic [ptx_pkg::PERIOD_W-1:0] slot_countdown [ptx_pkg::NUM_SLOTS];
  logic                         slot_pending   [ptx_pkg::NUM_SLOTS];
  logic                         send_queue     [ptx_pkg::QUEUE_DEPTH];
  logic [ptx_pkg::QIDX_W-1:0]   queue_head;
  logic [ptx_pkg::QCNT_W-1:0]   queue_count;
  logic                         mbox_busy      [ptx_pkg::NUM_MAILBOXES];
  ptx_pkg::result_t             sched_outcomes [$];

  // One tick walk or one service step against the tracked state.
  task automatic schedule_step(input logic kind,
                               input logic [ptx_pkg::MASK_W-1:0] done_mask,
                               output ptx_pkg::result_t res);
    int  pos;
    bit  walk_stop;
    res = '0;
    walk_stop = 1'b0;
    if (kind == ptx_pkg::KIND_TICK) begin
      for (int s = 0; s < ptx_pkg::NUM_SLOTS; s++) begin
        if (!walk_stop && slot_period[s] != '0) begin
          if (slot_countdown[s] != '0) begin
            slot_countdown[s] = slot_countdown[s] - 1'b1;
          end else begin
            slot_pending[s]   = 1'b1;
            slot_countdown[s] = slot_period[s];
          end
          if (slot_pending[s]) begin
            // full queue: keep the flag and skip the rest of the walk
            if (queue_count == ptx_pkg::QCNT_W'(ptx_pkg::QUEUE_DEPTH)) begin
              walk_stop = 1'b1;
            end else begin
              pos = int'(queue_head) + int'(queue_count);
              if (pos >= ptx_pkg::QUEUE_DEPTH) pos = pos - ptx_pkg::QUEUE_DEPTH;
              send_queue[pos] = (s != 0);
              queue_count     = queue_count + 1'b1;
              slot_pending[s] = 1'b0;
            end
          end
        end
      end
    end else begin
      for (int i = 0; i < ptx_pkg::NUM_MAILBOXES; i++) begin
        if (done_mask[i]) mbox_busy[i] = 1'b0;
      end
      if (queue_count != '0) begin
        res.message_slot = send_queue[queue_head];
        queue_head  = (queue_head == ptx_pkg::QIDX_W'(ptx_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : queue_head + 1'b1;
        queue_count = queue_count - 1'b1;
        res.dropped = 1'b1;
        for (int i = 0; i < ptx_pkg::NUM_MAILBOXES; i++) begin
          if (!res.assigned && !mbox_busy[i]) begin
            mbox_busy[i]   = 1'b1;
            res.assigned   = 1'b1;
            res.dropped    = 1'b0;
            res.mbox_index = ptx_pkg::MBOX_W'(i);
          end
        end
      end
    end
    res.queue_level = queue_count;
  endtask

  always @(posedge clk) begin
    ptx_pkg::result_t seen;
    ptx_pkg::result_t want;
    if (rst) begin
      for (int s = 0; s < ptx_pkg::NUM_SLOTS; s++) begin
        slot_period[s]    = '0;
        slot_countdown[s] = '0;
        slot_pending[s]   = 1'b0;
      end
      for (int i = 0; i < ptx_pkg::QUEUE_DEPTH; i++) send_queue[i] = 1'b0;
      for (int i = 0; i < ptx_pkg::NUM_MAILBOXES; i++) mbox_busy[i] = 1'b0;
      queue_head  = '0;
      queue_count = '0;
      sched_outcomes.delete();
    end else begin
      if (cfg_valid && cfg_ready &&
          cfg_index < ptx_pkg::CFG_INDEX_W'(ptx_pkg::NUM_SLOTS)) begin
        slot_period[cfg_index[0]]    = cfg_data;
        slot_countdown[cfg_index[0]] = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        schedule_step(s_axis_tuser, s_axis_tdata[ptx_pkg::MASK_W-1:0], want);
        sched_outcomes.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = ptx_pkg::result_t'(m_axis_tdata[ptx_pkg::RESULT_W-1:0]);
        if (sched_outcomes.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result word with nothing queued: %s%0d %0d %0d %0d %0d",
                     $realtime, "asg/mb/slot/drop/lvl = ", seen.assigned,
                     seen.mbox_index, seen.message_slot, seen.dropped,
                     seen.queue_level);
          fail_count++;
        end else begin
          want = sched_outcomes.pop_front();
          if (seen !== want) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp asg=%0d mb=%0d slot=%0d drop=%0d lvl=%0d,%s",
                       $realtime, want.assigned, want.mbox_index, want.message_slot,
                       want.dropped, want.queue_level,
                       $sformatf(" got asg=%0d mb=%0d slot=%0d drop=%0d lvl=%0d",
                                 seen.assigned, seen.mbox_index, seen.message_slot,
                                 seen.dropped, seen.queue_level));
            fail_count++;
          end
        end
      end
    end
    outstanding <= sched_outcomes.size();
  end

endmodule

// ===== tb/periodic_tx_scheduler_unit_test.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for periodic_tx_scheduler_unit: directed and random tick and
// service words under several period settings. Depends on ptx_pkg and the checker.
module periodic_tx_scheduler_unit_test;

  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} rx_mode_t;

  localparam int RANDOM_ITEMS = 1900;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [ptx_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;   // [2:0] tx_done_mask
  logic                            s_axis_tuser = 1'b0; // [0] kind
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [0] assigned, [2:1] mailbox, [3] message_slot, [4] dropped, [8:5] queue_level
  logic [ptx_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ptx_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ptx_pkg::PERIOD_W-1:0]    cfg_data = '0;
  int                              fail_count;
  int                              outstanding;

  int       burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_span = 0;
  int       rx_phase = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  periodic_tx_scheduler_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  periodic_tx_scheduler_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // Receiver: switch between stall patterns every so often.
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 200);
    end
    rx_span--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:         m_axis_tready <= 1'b1;
      RX_COIN:         m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_EVERY_FOURTH: m_axis_tready <= (rx_phase % 4 == 0);
      default:         m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Send one word; bursts of random length with idle gaps between them.
  task automatic push_event(input logic kind, input logic [ptx_pkg::MASK_W-1:0] done_mask);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= ptx_pkg::IN_DATA_W'(done_mask);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
  endtask

  // Hold input off until every queued result word has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [ptx_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ptx_pkg::PERIOD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Program both periods, optionally with a write to an unmapped index.
  task automatic apply_periods(input logic [ptx_pkg::PERIOD_W-1:0] pa,
                               input logic [ptx_pkg::PERIOD_W-1:0] pb,
                               input bit stray);
    if (stray)
      write_cfg(ptx_pkg::CFG_INDEX_W'($urandom_range(ptx_pkg::NUM_SLOTS, 255)),
                ptx_pkg::PERIOD_W'($urandom));
    write_cfg(ptx_pkg::CFG_PERIOD_A, pa);
    write_cfg(ptx_pkg::CFG_PERIOD_B, pb);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int                           done_items;
    int                           phase_len;
    int                           service_pct;
    logic                         kind;
    logic [ptx_pkg::MASK_W-1:0]   done_mask;
    logic [ptx_pkg::PERIOD_W-1:0] pa;
    logic [ptx_pkg::PERIOD_W-1:0] pb;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // slots off after reset; service with an empty queue
    push_event(ptx_pkg::KIND_TICK, 3'b000);
    push_event(ptx_pkg::KIND_SERVICE, 3'b111);
    drain_results();

    // shortest periods: fill the queue, then tick against a full queue
    apply_periods(16'd1, 16'd1, 1'b1);
    repeat (12) push_event(ptx_pkg::KIND_TICK, 3'b000);
    repeat (4) push_event(ptx_pkg::KIND_SERVICE, 3'b000);
    push_event(ptx_pkg::KIND_SERVICE, 3'b010);
    push_event(ptx_pkg::KIND_SERVICE, 3'b111);
    drain_results();

    // disable slot a while it still holds a pending flag; longest period on b
    apply_periods(16'd0, 16'hFFFF, 1'b0);
    repeat (2) push_event(ptx_pkg::KIND_TICK, 3'b000);
    repeat (2) push_event(ptx_pkg::KIND_SERVICE, 3'b111);
    drain_results();

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 6))
        0: begin pa = $urandom_range(1, 4);  pb = $urandom_range(1, 4); end
        1: begin pa = '0;                    pb = $urandom_range(1, 6); end
        2: begin pa = 16'hFFFF;              pb = $urandom_range(0, 2); end
        3: begin
          pa = ptx_pkg::PERIOD_W'($urandom);
          pb = ptx_pkg::PERIOD_W'($urandom);
        end
        4: begin pa = $urandom_range(0, 3);  pb = $urandom_range(0, 3); end
        5: begin pa = $urandom_range(1, 8);  pb = '0; end
        default: begin pa = $urandom_range(0, 20); pb = $urandom_range(0, 20); end
      endcase
      apply_periods(pa, pb, $urandom_range(0, 1) == 1);
      phase_len   = $urandom_range(80, 240);
      service_pct = $urandom_range(15, 85);
      for (int n = 0; n < phase_len; n++) begin
        kind      = ($urandom_range(0, 99) < service_pct) ? ptx_pkg::KIND_SERVICE
                                                          : ptx_pkg::KIND_TICK;
        done_mask = ($urandom_range(0, 2) == 0) ? '0
                                                : ptx_pkg::MASK_W'($urandom_range(0, 7));
        push_event(kind, done_mask);
      end
      done_items += phase_len;
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("periodic_tx_scheduler_unit_test passed");
    end else begin
      $display("periodic_tx_scheduler_unit_test failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("periodic_tx_scheduler_unit_test failed");
    $finish;
  end

endmodule
